FILE: rtl/ttip_pkg.sv
// text to integer parser package: character codes, parse phases, digit decode
// no dependencies
package ttip_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int OFFSET_BITS = 16;
    localparam int BASE_BITS   = 6;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 7;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_NUMBER_BASE = 2'd0;

    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LC_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UC_X  = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UC_Z  = 8'h5A;

    localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 7'd64;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 7'd10;

    typedef enum logic [5:0] {
        PH_SPACE     = 6'b000001,
        PH_PREFIX    = 6'b000010,
        PH_AUTO_ZERO = 6'b000100,
        PH_HEX_ZERO  = 6'b001000,
        PH_DIGITS    = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

    // digit value 0..35, or DIGIT_NONE for a non-alphanumeric code
    function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_BITS'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            d = DIGIT_BITS'(c - CH_LC_A) + DIGIT_TEN;
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            d = DIGIT_BITS'(c - CH_UC_A) + DIGIT_TEN;
        end
        return d;
    endfunction

endpackage

FILE: rtl/text_to_integer_parser_unit.sv
// text to integer parser top level: parse state, digit multiply-add, result register
// depends on ttip_pkg
//
// result: registered, it appears in the cycle after its stopping character is transferred
// throughput: one character per cycle while o_in_stall is low, set by the accumulator multiply-add feedback
// reset: number_base is 10, the parse waits for leading whitespace, no result is pending
module text_to_integer_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ttip_pkg::CHAR_BITS-1:0]  i_char_code,
    input  logic                            i_start_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [63:0]              o_parsed_value,
    output logic [ttip_pkg::OFFSET_BITS-1:0] o_end_offset,
    output logic [ttip_pkg::BASE_BITS-1:0]  o_base_used,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttip_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ttip_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ttip_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ttip_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic [BASE_BITS-1:0]    r_eff_base, n_eff_base;
    logic [OFFSET_BITS-1:0]  r_count, n_count;
    logic [BASE_BITS-1:0]    r_number_base;
    logic                    r_out_valid;
    logic signed [63:0]      r_out_value;
    logic [OFFSET_BITS-1:0]  r_out_offset;
    logic [BASE_BITS-1:0]    r_out_base;

    t_phase                  w_phase;
    logic [VALUE_BITS-1:0]   w_acc;
    logic                    w_neg;
    logic [OFFSET_BITS-1:0]  w_count;
    logic [OFFSET_BITS-1:0]  w_count_inc;
    logic [BASE_BITS-1:0]    w_cur_base;
    logic [BASE_BITS-1:0]    w_digit_base;
    logic                    w_to_digit;
    logic                    w_emit;
    logic [DIGIT_BITS-1:0]   w_digit;
    logic                    w_digit_ok;
    logic [VALUE_BITS+BASE_BITS-1:0] w_prod;
    logic [VALUE_BITS-1:0]   w_mac;
    logic [VALUE_BITS-1:0]   w_signed_val;
    logic                    w_accept;
    logic                    w_cfg_wr;
    logic                    w_ws;
    logic                    w_sign;
    logic                    w_is_x;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_NUMBER_BASE)
                        ? APB_DATA_W'(r_number_base) : '0;

    // state seen by this character, after an optional restart
    assign w_phase    = i_start_req ? PH_SPACE : r_phase;
    assign w_acc      = i_start_req ? '0 : r_acc;
    assign w_neg      = i_start_req ? 1'b0 : r_neg;
    assign w_count    = i_start_req ? '0 : r_count;
    assign w_cur_base = (w_phase == PH_SPACE || w_phase == PH_PREFIX)
                        ? r_number_base : r_eff_base;
    assign w_count_inc = (w_count == '1) ? w_count : w_count + 1'b1;

    assign w_ws   = (i_char_code == CH_SPACE) || (i_char_code == CH_TAB)
                 || (i_char_code == CH_LF);
    assign w_sign = (i_char_code == CH_MINUS) || (i_char_code == CH_PLUS);
    assign w_is_x = (i_char_code == CH_LC_X) || (i_char_code == CH_UC_X);

    assign w_digit    = digit_of(i_char_code);
    assign w_signed_val = w_neg ? (~w_acc + 1'b1) : w_acc;

    always_comb begin
        n_phase      = w_phase;
        n_acc        = w_acc;
        n_neg        = w_neg;
        n_count      = w_count;
        n_eff_base   = w_cur_base;
        w_digit_base = w_cur_base;
        w_to_digit   = 1'b0;
        w_emit       = 1'b0;
        unique case (w_phase)
            PH_SPACE, PH_PREFIX: begin
                if (w_phase == PH_SPACE && w_ws) begin
                    n_count = w_count_inc;
                end else if (w_phase == PH_SPACE && w_sign) begin
                    n_neg   = (i_char_code == CH_MINUS);
                    n_count = w_count_inc;
                    n_phase = PH_PREFIX;
                end else if (w_cur_base == BASE_AUTO) begin
                    if (i_char_code == CH_ZERO) begin
                        n_count = w_count_inc;
                        n_phase = PH_AUTO_ZERO;
                    end else begin
                        w_digit_base = BASE_DEC;
                        w_to_digit   = 1'b1;
                    end
                end else if (w_cur_base == BASE_HEX && i_char_code == CH_ZERO) begin
                    n_acc   = '0;
                    n_count = w_count_inc;
                    n_phase = PH_HEX_ZERO;
                end else begin
                    w_to_digit = 1'b1;
                end
            end
            PH_AUTO_ZERO, PH_HEX_ZERO: begin
                if (w_is_x) begin
                    n_eff_base = BASE_HEX;
                    n_count    = w_count_inc;
                    n_phase    = PH_DIGITS;
                end else begin
                    w_digit_base = (w_phase == PH_AUTO_ZERO) ? BASE_OCT : w_cur_base;
                    w_to_digit   = 1'b1;
                end
            end
            PH_DIGITS: begin
                w_to_digit = 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
        w_digit_ok = (i_char_code != CH_NUL)
                  && (w_digit < DIGIT_BITS'(w_digit_base));
        w_prod     = w_acc * w_digit_base;
        w_mac      = w_prod[VALUE_BITS-1:0] + VALUE_BITS'(w_digit);
        if (w_to_digit) begin
            n_eff_base = w_digit_base;
            if (w_digit_ok) begin
                n_acc   = w_mac;
                n_count = w_count_inc;
                n_phase = PH_DIGITS;
            end else begin
                w_emit  = 1'b1;
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SPACE;
            r_acc         <= '0;
            r_neg         <= 1'b0;
            r_eff_base    <= BASE_RESET;
            r_count       <= '0;
            r_number_base <= BASE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr == ADDR_NUMBER_BASE) begin
                r_number_base <= pwdata[BASE_BITS-1:0];
            end
            if (w_accept) begin
                r_phase    <= n_phase;
                r_acc      <= n_acc;
                r_neg      <= n_neg;
                r_eff_base <= n_eff_base;
                r_count    <= n_count;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_value  <= 64'($signed(w_signed_val));
            r_out_offset <= w_count;
            r_out_base   <= w_digit_base;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_out_value;
    assign o_end_offset   = r_out_offset;
    assign o_base_used    = r_out_base;

endmodule
